[hdl/wrt_pkg.sv]
package wrt_pkg;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_EST   = 2'd2;

    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_TOO_FEW  = 3'd1;
    localparam logic [2:0] ST_BAD_H    = 3'd2;
    localparam logic [2:0] ST_NONMONO  = 3'd3;
    localparam logic [2:0] ST_STALE    = 3'd4;
    localparam logic [2:0] ST_RECEDING = 3'd5;
    localparam logic [2:0] ST_CLAMPED  = 3'd6;

    localparam logic [2:0] CFG_WINDOW  = 3'd0;
    localparam logic [2:0] CFG_MIN     = 3'd1;
    localparam logic [2:0] CFG_STALE   = 3'd2;
    localparam logic [2:0] CFG_MAX_TTC = 3'd3;
    localparam logic [2:0] CFG_VFLOOR  = 3'd4;

    // quotient bits of the divider: ttc below 2^20, confidence at most 2^16
    localparam int QBITS = 21;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_SAMP,
        S_MDD,
        S_MHH,
        S_MDH,
        S_CHK,
        S_NSDD,
        S_SDSQ,
        S_A,
        S_B,
        S_NSHH,
        S_SHSQ,
        S_XYSQ,
        S_XXYY,
        S_DCONF,
        S_POS,
        S_SHXX,
        S_NDL,
        S_XYT,
        S_DEN,
        S_LIM,
        S_DTTC,
        S_DONE
    } wrt_state_t;

endpackage

[hdl/windowed_regression_ttc_top.sv]
// Looming time-to-collision from a sliding window of (timestamp, Q12.4 height) samples held in
// a ring memory. Add and clear transactions complete in the idle state. An estimate walks the
// window once through the memory (registered read), accumulating the regression sums with a
// shared bit-serial multiply-accumulate unit, then forms the fit with the same unit and a
// restoring divider. The multiplier runs only as long as its second operand has bits left. A
// window with too few samples is answered without the walk and the fit.
// One transaction is handled at a time; a finished result waits in the output register while
// the next input transaction is taken. There is no clearing pass after reset.
module windowed_regression_ttc_top
    import wrt_pkg::*;
#(
    parameter int MAX_WINDOW = 32,
    parameter int TIME_BITS  = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           kind,
    input  logic [TIME_BITS-1:0] timestamp_ms,
    input  logic signed [16:0]   height,
    input  logic [TIME_BITS-1:0] now_ms,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 valid_res,
    output logic [2:0]           status,
    output logic [19:0]          ttc_ms,
    output logic [15:0]          confidence,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [19:0]          cfg_data
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = (CW > 6) ? CW : 6;
    localparam int TW = TIME_BITS;
    localparam int BW = 2 * TIME_BITS + 4 * CW + 56;

    wrt_state_t state_reg, state_next;

    logic [AW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [5:0]    ws_reg, ms_reg;
    logic [15:0]   stale_reg, vfloor_reg;
    logic [19:0]   maxttc_reg;
    logic          go_reg, go_next;
    logic          ovalid_reg, ovalid_next;

    logic [TW-1:0] now_reg, now_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [TW-1:0] t0_reg, t0_next;
    logic [TW-1:0] tprev_reg, tprev_next;
    logic [TW-1:0] d_reg, d_next;
    logic [16:0]   h_reg, h_next;
    logic          bad_reg, bad_next;
    logic          mono_reg, mono_next;
    logic          pos_reg, pos_next;
    logic [BW-1:0] sd_reg, sd_next;
    logic [BW-1:0] sh_reg, sh_next;
    logic [BW-1:0] sdd_reg, sdd_next;
    logic [BW-1:0] shh_reg, shh_next;
    logic [BW-1:0] sdh_reg, sdh_next;
    logic [BW-1:0] nxx_reg, nxx_next;
    logic [BW-1:0] nyy_reg, nyy_next;
    logic [BW-1:0] nxy_reg, nxy_next;
    logic [BW-1:0] t1_reg, t1_next;
    logic [BW-1:0] t2_reg, t2_next;
    logic [BW-1:0] den_reg, den_next;
    logic [BW-1:0] num_reg, num_next;
    logic [BW-1:0] fl_reg, fl_next;
    logic [2:0]    stat_reg, stat_next;
    logic [19:0]   ttc_reg, ttc_next;
    logic [15:0]   conf_reg, conf_next;
    logic [2:0]    ostat_reg, ostat_next;
    logic [19:0]   ottc_reg, ottc_next;
    logic [15:0]   oconf_reg, oconf_next;

    logic             in_acc;
    logic [EW-1:0]    ms_e, ws_e, m_eff, w_tmp, w_eff;
    logic             full;
    logic [AW-1:0]    o1;
    logic [CW-1:0]    c1, c2;
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [TW-1:0]    rtime, dcur;
    logic [16:0]      rheight;
    logic             mul_state, div_state, mul_start, div_start, mul_busy, div_busy;
    logic             mul_fin, div_fin;
    logic [BW-1:0]    mul_a, mul_b, mul_acc, mul_prod, diff;
    logic [BW-1:0]    div_num, div_den;
    logic [QBITS-1:0] quot;
    logic [BW-1:0]    n_w;

    function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
        logic [CW:0] r;
        r = v;
        if (v >= (CW+1)'(MAX_WINDOW))
        begin
            r = v - (CW+1)'(MAX_WINDOW);
        end
        return AW'(r);
    endfunction

    wrt_ring #(.DEPTH(MAX_WINDOW), .TW(TW), .AW(AW)) u_ring (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wtime   (timestamp_ms),
        .wheight (height),
        .re      (re),
        .raddr   (raddr),
        .rtime   (rtime),
        .rheight (rheight)
    );

    wrt_mul #(.W(BW)) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .acc_in (mul_acc),
        .busy   (mul_busy),
        .prod   (mul_prod)
    );

    wrt_div #(.W(BW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (quot)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign out_valid  = ovalid_reg;
    assign valid_res  = (ostat_reg == ST_VALID);
    assign status     = ostat_reg;
    assign ttc_ms     = ottc_reg;
    assign confidence = oconf_reg;

    assign mul_fin = go_reg && !mul_busy;
    assign div_fin = go_reg && !div_busy;
    assign diff    = t1_reg - mul_prod;
    assign n_w     = BW'(cnt_reg);
    assign dcur    = (idx_reg == '0) ? '0 : rtime - t0_reg;

    // effective window: at least the effective minimum, at most the ring depth
    always_comb
    begin
        ms_e  = EW'(ms_reg);
        ws_e  = EW'(ws_reg);
        m_eff = (ms_e < EW'(2)) ? EW'(2) : ms_e;
        w_tmp = (ws_e < m_eff) ? m_eff : ws_e;
        w_eff = (w_tmp > EW'(MAX_WINDOW)) ? EW'(MAX_WINDOW) : w_tmp;
    end

    always_comb
    begin
        full = (cnt_reg == CW'(MAX_WINDOW));
        o1   = full ? wrap((CW+1)'(oldest_reg) + (CW+1)'(1)) : oldest_reg;
        c1   = full ? cnt_reg - CW'(1) : cnt_reg;
        c2   = c1 + CW'(1);
        waddr = wrap((CW+1)'(o1) + (CW+1)'(c1));
        raddr = wrap((CW+1)'(oldest_reg) + (CW+1)'(idx_reg));
    end

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        cnt_next    = cnt_reg;
        go_next     = go_reg;
        ovalid_next = (ovalid_reg && !out_stall) ? 1'b0 : ovalid_reg;
        now_next    = now_reg;
        idx_next    = idx_reg;
        t0_next     = t0_reg;
        tprev_next  = tprev_reg;
        d_next      = d_reg;
        h_next      = h_reg;
        bad_next    = bad_reg;
        mono_next   = mono_reg;
        pos_next    = pos_reg;
        sd_next     = sd_reg;
        sh_next     = sh_reg;
        sdd_next    = sdd_reg;
        shh_next    = shh_reg;
        sdh_next    = sdh_reg;
        nxx_next    = nxx_reg;
        nyy_next    = nyy_reg;
        nxy_next    = nxy_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        fl_next     = fl_reg;
        stat_next   = stat_reg;
        ttc_next    = ttc_reg;
        conf_next   = conf_reg;
        ostat_next  = ostat_reg;
        ottc_next   = ottc_reg;
        oconf_next  = oconf_reg;
        we          = 1'b0;
        re          = 1'b0;
        mul_state   = 1'b0;
        div_state   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        mul_acc     = '0;
        div_num     = t1_reg;
        div_den     = den_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind)
                        KIND_ADD:
                        begin
                            we = 1'b1;
                            if (EW'(c2) > w_eff)
                            begin
                                oldest_next = wrap((CW+1)'(o1) + (CW+1)'(c2 - CW'(w_eff)));
                                cnt_next    = CW'(w_eff);
                            end
                            else
                            begin
                                oldest_next = o1;
                                cnt_next    = c2;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            oldest_next = '0;
                            cnt_next    = '0;
                        end
                        KIND_EST:
                        begin
                            now_next   = now_ms;
                            state_next = S_START;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_START:
            begin
                ttc_next  = '0;
                conf_next = '0;
                if (EW'(cnt_reg) < m_eff)
                begin
                    stat_next  = ST_TOO_FEW;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = '0;
                    bad_next   = 1'b0;
                    mono_next  = 1'b0;
                    sd_next    = '0;
                    sh_next    = '0;
                    sdd_next   = '0;
                    shh_next   = '0;
                    sdh_next   = '0;
                    fl_next    = BW'(cnt_reg) * BW'(vfloor_reg);
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                re         = 1'b1;
                state_next = S_SAMP;
            end
            S_SAMP:
            begin
                if (idx_reg == '0)
                begin
                    t0_next = rtime;
                end
                else if (rtime <= tprev_reg)
                begin
                    mono_next = 1'b1;
                end
                if (rheight == '0 || rheight[16])
                begin
                    bad_next = 1'b1;
                end
                tprev_next = rtime;
                d_next     = dcur;
                h_next     = rheight;
                sd_next    = sd_reg + BW'(dcur);
                sh_next    = sh_reg + BW'(rheight);
                state_next = S_MDD;
            end
            S_MDD:
            begin
                mul_state = 1'b1;
                mul_a     = BW'(d_reg);
                mul_b     = BW'(d_reg);
                mul_acc   = sdd_reg;
                if (mul_fin)
                begin
                    sdd_next   = mul_prod;
                    state_next = S_MHH;
                end
            end
            S_MHH:
            begin
                mul_state = 1'b1;
                mul_a     = BW'(h_reg);
                mul_b     = BW'(h_reg);
                mul_acc   = shh_reg;
                if (mul_fin)
                begin
                    shh_next   = mul_prod;
                    state_next = S_MDH;
                end
            end
            S_MDH:
            begin
                mul_state = 1'b1;
                mul_a     = BW'(d_reg);
                mul_b     = BW'(h_reg);
                mul_acc   = sdh_reg;
                if (mul_fin)
                begin
                    sdh_next = mul_prod;
                    idx_next = idx_reg + CW'(1);
                    if (idx_reg + CW'(1) == cnt_reg)
                    begin
                        state_next = S_CHK;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_CHK:
            begin
                if (bad_reg)
                begin
                    stat_next  = ST_BAD_H;
                    state_next = S_DONE;
                end
                else if (mono_reg)
                begin
                    stat_next  = ST_NONMONO;
                    state_next = S_DONE;
                end
                else if (now_reg > tprev_reg && (now_reg - tprev_reg) > TW'(stale_reg))
                begin
                    stat_next  = ST_STALE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_NSDD;
                end
            end
            S_NSDD:
            begin
                mul_state = 1'b1;
                mul_a     = sdd_reg;
                mul_b     = n_w;
                if (mul_fin)
                begin
                    t1_next    = mul_prod;
                    state_next = S_SDSQ;
                end
            end
            S_SDSQ:
            begin
                mul_state = 1'b1;
                mul_a     = sd_reg;
                mul_b     = sd_reg;
                if (mul_fin)
                begin
                    nxx_next = diff;
                    if (diff <= fl_reg)
                    begin
                        stat_next  = ST_NONMONO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_A;
                    end
                end
            end
            S_A:
            begin
                mul_state = 1'b1;
                mul_a     = sdh_reg;
                mul_b     = n_w;
                if (mul_fin)
                begin
                    t1_next    = mul_prod;
                    state_next = S_B;
                end
            end
            S_B:
            begin
                mul_state = 1'b1;
                mul_a     = sd_reg;
                mul_b     = sh_reg;
                if (mul_fin)
                begin
                    pos_next   = (t1_reg > mul_prod);
                    nxy_next   = (t1_reg > mul_prod) ? diff : mul_prod - t1_reg;
                    state_next = S_NSHH;
                end
            end
            S_NSHH:
            begin
                mul_state = 1'b1;
                mul_a     = shh_reg;
                mul_b     = n_w;
                if (mul_fin)
                begin
                    t1_next    = mul_prod;
                    state_next = S_SHSQ;
                end
            end
            S_SHSQ:
            begin
                mul_state = 1'b1;
                mul_a     = sh_reg;
                mul_b     = sh_reg;
                if (mul_fin)
                begin
                    nyy_next = diff;
                    if (diff > fl_reg && nxy_reg != '0)
                    begin
                        state_next = S_XYSQ;
                    end
                    else
                    begin
                        state_next = S_POS;
                    end
                end
            end
            S_XYSQ:
            begin
                mul_state = 1'b1;
                mul_a     = nxy_reg;
                mul_b     = nxy_reg;
                if (mul_fin)
                begin
                    t1_next    = mul_prod << 16;
                    state_next = S_XXYY;
                end
            end
            S_XXYY:
            begin
                mul_state = 1'b1;
                mul_a     = nxx_reg;
                mul_b     = nyy_reg;
                if (mul_fin)
                begin
                    den_next   = mul_prod;
                    state_next = S_DCONF;
                end
            end
            S_DCONF:
            begin
                div_state = 1'b1;
                if (div_fin)
                begin
                    conf_next  = (quot[QBITS-1:16] != '0) ? 16'hFFFF : quot[15:0];
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                if (!pos_reg)
                begin
                    stat_next  = ST_RECEDING;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHXX;
                end
            end
            S_SHXX:
            begin
                mul_state = 1'b1;
                mul_a     = nxx_reg;
                mul_b     = sh_reg;
                if (mul_fin)
                begin
                    t1_next    = mul_prod;
                    state_next = S_NDL;
                end
            end
            S_NDL:
            begin
                mul_state = 1'b1;
                mul_a     = BW'(tprev_reg - t0_reg);
                mul_b     = n_w;
                if (mul_fin)
                begin
                    t2_next    = mul_prod - sd_reg;
                    state_next = S_XYT;
                end
            end
            S_XYT:
            begin
                mul_state = 1'b1;
                mul_a     = nxy_reg;
                mul_b     = t2_reg;
                mul_acc   = t1_reg;
                if (mul_fin)
                begin
                    num_next   = mul_prod;
                    state_next = S_DEN;
                end
            end
            S_DEN:
            begin
                mul_state = 1'b1;
                mul_a     = nxy_reg;
                mul_b     = n_w;
                if (mul_fin)
                begin
                    den_next   = mul_prod;
                    state_next = S_LIM;
                end
            end
            S_LIM:
            begin
                mul_state = 1'b1;
                mul_a     = den_reg;
                mul_b     = BW'(maxttc_reg);
                if (mul_fin)
                begin
                    if (num_reg > mul_prod)
                    begin
                        stat_next  = ST_CLAMPED;
                        ttc_next   = maxttc_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DTTC;
                    end
                end
            end
            S_DTTC:
            begin
                div_state = 1'b1;
                div_num   = num_reg;
                if (div_fin)
                begin
                    stat_next  = ST_VALID;
                    ttc_next   = quot[19:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = stat_reg;
                    ottc_next   = ttc_reg;
                    oconf_next  = conf_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mul_start = mul_state && !go_reg;
        div_start = div_state && !go_reg;
        if (mul_state)
        begin
            go_next = !go_reg || mul_busy;
        end
        else if (div_state)
        begin
            go_next = !go_reg || div_busy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            oldest_reg <= '0;
            cnt_reg    <= '0;
            go_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            ws_reg     <= 6'd8;
            ms_reg     <= 6'd3;
            stale_reg  <= 16'd500;
            maxttc_reg <= 20'd10000;
            vfloor_reg <= 16'd0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            cnt_reg    <= cnt_next;
            go_reg     <= go_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_WINDOW:  ws_reg     <= cfg_data[5:0];
                    CFG_MIN:     ms_reg     <= cfg_data[5:0];
                    CFG_STALE:   stale_reg  <= cfg_data[15:0];
                    CFG_MAX_TTC: maxttc_reg <= cfg_data;
                    CFG_VFLOOR:  vfloor_reg <= cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        idx_reg   <= idx_next;
        t0_reg    <= t0_next;
        tprev_reg <= tprev_next;
        d_reg     <= d_next;
        h_reg     <= h_next;
        bad_reg   <= bad_next;
        mono_reg  <= mono_next;
        pos_reg   <= pos_next;
        sd_reg    <= sd_next;
        sh_reg    <= sh_next;
        sdd_reg   <= sdd_next;
        shh_reg   <= shh_next;
        sdh_reg   <= sdh_next;
        nxx_reg   <= nxx_next;
        nyy_reg   <= nyy_next;
        nxy_reg   <= nxy_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        fl_reg    <= fl_next;
        stat_reg  <= stat_next;
        ttc_reg   <= ttc_next;
        conf_reg  <= conf_next;
        ostat_reg <= ostat_next;
        ottc_reg  <= ottc_next;
        oconf_reg <= oconf_next;
    end

endmodule

[hdl/wrt_ring.sv]
module wrt_ring
    import wrt_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int TW    = 48,
    parameter int AW    = 5
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [TW-1:0] wtime,
    input  logic [16:0]   wheight,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [TW-1:0] rtime,
    output logic [16:0]   rheight
);

    logic [TW-1:0] time_mem [DEPTH];
    logic [16:0]   height_mem [DEPTH];
    logic [TW-1:0] rtime_reg;
    logic [16:0]   rheight_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            time_mem[waddr]   <= wtime;
            height_mem[waddr] <= wheight;
        end
        if (re)
        begin
            rtime_reg   <= time_mem[raddr];
            rheight_reg <= height_mem[raddr];
        end
    end

    assign rtime   = rtime_reg;
    assign rheight = rheight_reg;

endmodule

[hdl/wrt_mul.sv]
module wrt_mul
    import wrt_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] acc_in,
    output logic         busy,
    output logic [W-1:0] prod
);

    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] acc_reg;

    // shift-add, one multiplier bit per cycle, stops once the multiplier is used up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (start)
        begin
            b_reg <= b;
        end
        else if (b_reg != '0)
        begin
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= acc_in;
        end
        else if (b_reg != '0)
        begin
            a_reg <= a_reg << 1;
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
        end
    end

    assign busy = (b_reg != '0);
    assign prod = acc_reg;

endmodule

[hdl/wrt_div.sv]
module wrt_div
    import wrt_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [W-1:0]     num,
    input  logic [W-1:0]     den,
    output logic             busy,
    output logic [QBITS-1:0] quot
);

    localparam int QCW = $clog2(QBITS + 1);

    logic [QCW-1:0]   cnt_reg;
    logic [W-1:0]     r_reg;
    logic [W-1:0]     ds_reg;
    logic [QBITS-1:0] q_reg;

    // restoring division, one quotient bit per cycle; caller keeps num below den << QBITS
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= QCW'(QBITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg  <= num;
            ds_reg <= den << (QBITS - 1);
            q_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            ds_reg <= ds_reg >> 1;
            if (r_reg >= ds_reg)
            begin
                r_reg <= r_reg - ds_reg;
                q_reg <= {q_reg[QBITS-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QBITS-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;

endmodule

[sim/tb_windowed_regression_ttc_top.sv]
module tb_windowed_regression_ttc_top;
    import wrt_pkg::*;

    localparam int              NSLOT      = 32;
    localparam int              WD_LIMIT   = 40000;
    localparam int              ITEM_COUNT = 1350;
    localparam logic [2:0]      CFG_SPARE  = 3'd5;
    localparam logic [1:0]      KIND_NONE  = 2'd3;
    localparam logic [47:0]     T_MAX      = 48'hFFFF_FFFF_FFFF;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic        usable;
        logic [2:0]  st;
        logic [19:0] ttc;
        logic [15:0] conf;
    } ttc_res_t;

    class ttc_scoreboard;
        logic [47:0] t_ring [NSLOT];
        logic [16:0] h_ring [NSLOT];
        int unsigned head;
        int unsigned fill;
        int unsigned win_reg, min_reg, stale_reg, max_reg, floor_reg;
        ttc_res_t    pending [$];
        int unsigned n_err;

        function new();
            head = 0; fill = 0; n_err = 0;
            win_reg = 8; min_reg = 3; stale_reg = 500; max_reg = 10000; floor_reg = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] val);
            case (idx)
                CFG_WINDOW:  win_reg = val[5:0];
                CFG_MIN:     min_reg = val[5:0];
                CFG_STALE:   stale_reg = val[15:0];
                CFG_MAX_TTC: max_reg = val[19:0];
                CFG_VFLOOR:  floor_reg = val[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned min_eff();
            return (min_reg < 2) ? 2 : min_reg;
        endfunction

        function int unsigned win_eff();
            int unsigned w;
            w = win_reg;
            if (w < min_eff()) w = min_eff();
            if (w > NSLOT) w = NSLOT;
            return w;
        endfunction

        function int unsigned at(int unsigned i);
            return (head + i) % NSLOT;
        endfunction

        function ttc_res_t fit_window(logic [47:0] now);
            ttc_res_t    r;
            int unsigned n, i;
            logic [47:0] t0, newest;
            wide_t       sd, sdd, sh, shh, sdh, d, h, wn, fl, nxx, nyy, nxy, a, b;
            wide_t       num, den, lim, q;
            logic        pos;
            r = '0;
            n = fill;
            r.st = ST_TOO_FEW;
            if (n < min_eff()) return r;
            r.st = ST_BAD_H;
            for (i = 0; i < n; i++)
                if (h_ring[at(i)] == 0 || h_ring[at(i)][16]) return r;
            r.st = ST_NONMONO;
            for (i = 1; i < n; i++)
                if (t_ring[at(i)] <= t_ring[at(i-1)]) return r;
            newest = t_ring[at(n-1)];
            r.st = ST_STALE;
            if (now > newest && (now - newest) > stale_reg) return r;
            t0 = t_ring[at(0)];
            sd = 0; sdd = 0; sh = 0; shh = 0; sdh = 0;
            for (i = 0; i < n; i++)
            begin
                d = wide_t'(t_ring[at(i)] - t0);
                h = wide_t'(h_ring[at(i)]);
                sd += d; sdd += d * d; sh += h; shh += h * h; sdh += d * h;
            end
            wn = n;
            fl = wide_t'(floor_reg) * wn;
            nxx = wn * sdd - sd * sd;
            r.st = ST_NONMONO;
            if (nxx <= fl) return r;
            a = wn * sdh;
            b = sd * sh;
            pos = a > b;
            nxy = pos ? a - b : b - a;
            nyy = wn * shh - sh * sh;
            if (nyy > fl && nxy != 0)
            begin
                q = (nxy * nxy * wide_t'(65536)) / (nxx * nyy);
                r.conf = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            if (!pos)
            begin
                r.st = ST_RECEDING;
                return r;
            end
            num = sh * nxx + nxy * (wn * wide_t'(newest - t0) - sd);
            den = wn * nxy;
            lim = wide_t'(max_reg) * den;
            if (num > lim)
            begin
                r.st = ST_CLAMPED;
                r.ttc = max_reg;
                return r;
            end
            q = num / den;
            r.st = ST_VALID;
            r.usable = 1'b1;
            r.ttc = q[19:0];
            return r;
        endfunction

        function void note_input(logic [1:0] k, logic [47:0] ts, logic [16:0] hv,
                                 logic [47:0] now);
            int unsigned w;
            case (k)
                KIND_ADD:
                begin
                    w = win_eff();
                    if (fill >= NSLOT)
                    begin
                        head = (head + 1) % NSLOT; fill--;
                    end
                    t_ring[at(fill)] = ts;
                    h_ring[at(fill)] = hv;
                    fill++;
                    while (fill > w)
                    begin
                        head = (head + 1) % NSLOT; fill--;
                    end
                end
                KIND_CLEAR:
                begin
                    fill = 0; head = 0;
                end
                KIND_EST: pending.push_back(fit_window(now));
                default: ;
            endcase
        endfunction

        function void check_result(ttc_res_t got);
            ttc_res_t want;
            if (pending.size() == 0)
            begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                n_err++;
                if (n_err <= 10) $display("mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          kind;
    logic [47:0]         timestamp_ms;
    logic signed [16:0]  height;
    logic [47:0]         now_ms;
    logic                out_valid;
    logic                out_stall;
    logic                valid_res;
    logic [2:0]          status;
    logic [19:0]         ttc_ms;
    logic [15:0]         confidence;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [19:0]         cfg_data;

    ttc_scoreboard sb;
    int unsigned   idle_cycles;
    int unsigned   stall_left;
    int unsigned   quiet_left;
    int unsigned   n_items;

    windowed_regression_ttc_top i_dut (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{valid_res, status, ttc_ms, confidence});
        if (quiet_left > 0)
        begin
            quiet_left--;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 99)) inside
                [0:59]:  out_stall <= 1'b0;
                [60:89]:
                begin
                    stall_left = $urandom_range(0, 2);
                    out_stall <= 1'b1;
                end
                [90:96]:
                begin
                    stall_left = $urandom_range(20, 80);
                    out_stall <= 1'b1;
                end
                default:
                begin
                    quiet_left = $urandom_range(100, 600);
                    out_stall <= 1'b0;
                end
            endcase
        end
    end

    task automatic send(logic [1:0] k, logic [47:0] ts, logic [16:0] hv, logic [47:0] now);
        kind <= k;
        timestamp_ms <= ts;
        height <= hv;
        now_ms <= now;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_input(k, ts, hv, now);
        if (k != KIND_NONE) n_items++;
    endtask

    task automatic pause_in();
        int unsigned g;
        case ($urandom_range(0, 9)) inside
            [0:5]: g = 0;
            [6:8]: g = $urandom_range(1, 3);
            default: g = $urandom_range(10, 60);
        endcase
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic add(logic [47:0] ts, logic [16:0] hv);
        send(KIND_ADD, ts, hv, '0);
        pause_in();
    endtask

    task automatic estimate(logic [47:0] now);
        send(KIND_EST, $urandom, $urandom, now);
        pause_in();
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [19:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_phase(int p);
        case (p)
            0: begin write_cfg(CFG_WINDOW, 2);  write_cfg(CFG_MIN, 2);
                     write_cfg(CFG_STALE, 0);   write_cfg(CFG_MAX_TTC, 1);
                     write_cfg(CFG_VFLOOR, 0); end
            1: begin write_cfg(CFG_WINDOW, 32); write_cfg(CFG_MIN, 32);
                     write_cfg(CFG_STALE, 16'hFFFF); write_cfg(CFG_MAX_TTC, 20'hFFFFF);
                     write_cfg(CFG_VFLOOR, 16'hFFFF); end
            2: begin write_cfg(CFG_WINDOW, 63); write_cfg(CFG_MIN, 0);
                     write_cfg(CFG_STALE, 1000); write_cfg(CFG_MAX_TTC, 50000);
                     write_cfg(CFG_VFLOOR, 100); end
            3: begin write_cfg(CFG_WINDOW, 4);  write_cfg(CFG_MIN, 40);
                     write_cfg(CFG_STALE, 200); write_cfg(CFG_VFLOOR, 0); end
            4: begin write_cfg(CFG_WINDOW, 10); write_cfg(CFG_MIN, 5);
                     write_cfg(CFG_STALE, 16'hFFFF); write_cfg(CFG_MAX_TTC, 20'hFFFFF);
                     write_cfg(CFG_SPARE, 20'h5A5A5); end
            default: begin write_cfg(CFG_WINDOW, 6); write_cfg(CFG_MIN, 3);
                     write_cfg(CFG_STALE, 500); write_cfg(CFG_MAX_TTC, 10000);
                     write_cfg(CFG_VFLOOR, 20); end
        endcase
    endtask

    task automatic random_burst();
        int unsigned len, i;
        logic [47:0] t, newest;
        int          hv, rise;
        bit          clean;
        clean = $urandom_range(0, 99) < 80;
        if ($urandom_range(0, 9) < 8) send(KIND_CLEAR, $urandom, $urandom, $urandom);
        len = ($urandom_range(0, 9) < 8) ? sb.min_eff() + $urandom_range(0, 4)
                                         : $urandom_range(1, 12);
        if (len > 36) len = 36;
        t = {$urandom, $urandom};
        if (t > T_MAX - 48'd20000) t = t - 48'd40000;
        hv = $urandom_range(16, 20000);
        rise = $urandom_range(0, 900) - 300;
        newest = t;
        for (i = 0; i < len; i++)
        begin
            if (clean)
            begin
                t = t + $urandom_range(1, 120);
                hv = hv + rise + $urandom_range(0, 40) - 20;
                if (hv < 1) hv = 1;
                if (hv > 65535) hv = 65535;
                add(t, hv[16:0]);
            end
            else
            begin
                t = ($urandom_range(0, 3) == 0) ? t : t + $urandom_range(0, 50) - 10;
                add(t, ($urandom_range(0, 3) == 0) ? 17'($urandom) : hv[16:0]);
            end
            newest = t;
            if ($urandom_range(0, 40) == 0) send(KIND_NONE, $urandom, $urandom, $urandom);
        end
        case ($urandom_range(0, 9)) inside
            [0:6]: estimate(newest + $urandom_range(0, sb.stale_reg));
            7:     estimate(newest - $urandom_range(0, 500));
            8:     estimate(newest + sb.stale_reg + $urandom_range(1, 1000));
            default: estimate({$urandom, $urandom});
        endcase
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_ADD;
        timestamp_ms = '0;
        height = '0;
        now_ms = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data = '0;
        idle_cycles = 0;
        stall_left = 0;
        quiet_left = 0;
        n_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(CFG_WINDOW, 8);
        write_cfg(CFG_MIN, 3);
        write_cfg(CFG_STALE, 500);
        write_cfg(CFG_MAX_TTC, 10000);
        write_cfg(CFG_VFLOOR, 0);

        estimate(48'd0);
        send(KIND_NONE, T_MAX, 17'h1FFFF, T_MAX);
        add(48'd0, 17'h0FFFF);
        add(48'd1, 17'h10000);
        add(48'd2, 17'h00000);
        estimate(48'd2);
        send(KIND_CLEAR, '0, '0, '0);
        add(48'd100, 17'd1600);
        add(48'd133, 17'd1700);
        add(48'd166, 17'd1800);
        estimate(48'd166);
        estimate(48'd0);
        estimate(T_MAX);
        add(48'd166, 17'd1900);
        estimate(48'd166);
        send(KIND_CLEAR, '0, '0, '0);
        add(T_MAX - 2, 17'd2000);
        add(T_MAX - 1, 17'd1900);
        add(T_MAX, 17'd1800);
        estimate(T_MAX);
        send(KIND_CLEAR, '0, '0, '0);
        add(48'd1000, 17'd1000);
        add(48'd1010, 17'd1001);
        add(48'd1020, 17'd1002);
        estimate(48'd1020);
        add(48'd1030, 17'd1002);
        add(48'd1040, 17'd1002);
        estimate(48'd1040);

        for (int p = 0; p < 6; p++)
        begin
            settle();
            load_phase(p);
            while (n_items < (p + 1) * ITEM_COUNT / 6 + 25) random_burst();
        end
        settle();
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
